FILE: hw/rtl/tpba_pkg.sv
// shared types and codes for the threshold priority batch admitter
package tpba_pkg;

    localparam int PRES_W = 16;
    localparam int TAG_W  = 16;
    localparam int MB_W   = 5;
    localparam int CFG_W  = 16;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MAX_BATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_ADMITTED = 2'd2,
        ST_NONE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } t_op;

    // one slot of the queue
    typedef struct packed {
        logic              valid;
        logic [PRES_W-1:0] pressure;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        t_op               op;
        logic [PRES_W-1:0] pressure;
        logic [TAG_W-1:0]  tag;
    } t_chain_op;

endpackage

FILE: hw/rtl/tpba_cell.sv
// one queue slot of the sorted cell chain
module tpba_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tpba_pkg::t_chain_op i_op,
    input  tpba_pkg::t_entry   i_left,
    input  logic               i_left_stay,
    input  tpba_pkg::t_entry   i_right,
    output tpba_pkg::t_entry   o_entry,
    output logic               o_stay
);
    import tpba_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // entry keeps its slot when it ranks at or above the new one
    assign o_stay  = r_entry.valid && (r_entry.pressure >= i_op.pressure);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op.op)
            OP_INSERT: begin
                if (o_stay) begin
                    n_entry = r_entry;
                end else if (i_left_stay) begin
                    n_entry.valid    = 1'b1;
                    n_entry.pressure = i_op.pressure;
                    n_entry.tag      = i_op.tag;
                end else begin
                    n_entry = i_left;
                end
            end
            OP_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

FILE: hw/rtl/tpba_ctrl.sv
// command sequencer, configuration registers and result register
module tpba_ctrl #(
    parameter int MAX_BATCH_LIMIT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tpba_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [tpba_pkg::PRES_W-1:0]   i_pressure,
    input  logic [tpba_pkg::TAG_W-1:0]    i_query_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [tpba_pkg::TAG_W-1:0]    o_admitted_tag,
    output logic [tpba_pkg::PRES_W-1:0]   o_admitted_pressure,
    output logic                          o_last,
    input  tpba_pkg::t_entry              i_head,
    input  tpba_pkg::t_entry              i_second,
    input  logic                          i_full,
    output tpba_pkg::t_chain_op           o_chain_op
);
    import tpba_pkg::*;

    localparam int LIM_W = $clog2(MAX_BATCH_LIMIT + 1);
    localparam int CMP_W = (LIM_W > MB_W) ? LIM_W : MB_W;

    typedef enum logic {
        S_IDLE,
        S_ADMIT
    } t_state;

    t_state            r_state, n_state;
    logic [PRES_W-1:0] r_thr;
    logic [MB_W-1:0]   r_max_batch;
    logic [LIM_W-1:0]  r_limit, n_limit;
    logic [LIM_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [PRES_W-1:0] r_pres, n_pres;
    logic              r_last, n_last;

    logic              can_out;
    logic              in_acc;
    logic              head_q;
    logic              second_q;
    logic [CMP_W-1:0]  mb_ext;
    logic [LIM_W-1:0]  limit_clamped;

    assign can_out    = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && can_out;
    assign in_acc     = i_in_valid && o_in_ready;
    assign head_q     = i_head.valid && (i_head.pressure >= r_thr);
    assign second_q   = i_second.valid && (i_second.pressure >= r_thr);
    assign mb_ext     = CMP_W'(r_max_batch);

    always_comb begin
        if (r_max_batch == '0) begin
            limit_clamped = LIM_W'(1);
        end else if (mb_ext > CMP_W'(MAX_BATCH_LIMIT)) begin
            limit_clamped = LIM_W'(MAX_BATCH_LIMIT);
        end else begin
            limit_clamped = LIM_W'(mb_ext);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_tag       = r_tag;
        n_pres      = r_pres;
        n_last      = r_last;
        o_chain_op.op       = OP_HOLD;
        o_chain_op.pressure = i_pressure;
        o_chain_op.tag      = i_query_tag;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_cmd) begin
                        n_out_valid = 1'b1;
                        n_status    = i_full ? ST_REJECTED : ST_ENQUEUED;
                        n_tag       = '0;
                        n_pres      = '0;
                        n_last      = 1'b1;
                        if (!i_full) begin
                            o_chain_op.op = OP_INSERT;
                        end
                    end else begin
                        n_limit = limit_clamped;
                        n_cnt   = '0;
                        n_state = S_ADMIT;
                    end
                end
            end
            S_ADMIT: begin
                if (can_out) begin
                    n_out_valid = 1'b1;
                    if (head_q) begin
                        // emit head, shift the chain one slot toward the head
                        o_chain_op.op = OP_POP;
                        n_status = ST_ADMITTED;
                        n_tag    = i_head.tag;
                        n_pres   = i_head.pressure;
                        n_last   = (LIM_W'(r_cnt + 1'b1) == r_limit) || !second_q;
                        n_cnt    = LIM_W'(r_cnt + 1'b1);
                        if (n_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_status = ST_NONE;
                        n_tag    = '0;
                        n_pres   = '0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= '0;
            r_max_batch <= MB_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_limit     <= n_limit;
            r_cnt       <= n_cnt;
            r_status    <= n_status;
            r_tag       <= n_tag;
            r_pres      <= n_pres;
            r_last      <= n_last;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: r_thr       <= i_cfg_data[PRES_W-1:0];
                    CFG_MAX_BATCH: r_max_batch <= i_cfg_data[MB_W-1:0];
                    default:       r_thr       <= r_thr;
                endcase
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_admitted_tag      = r_tag;
    assign o_admitted_pressure = r_pres;
    assign o_last              = r_last;

    a_no_insert_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_chain_op.op == OP_INSERT) |-> !i_full)
        else $error("insert issued into a full chain");

    a_admitted_meets_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_ADMITTED) |-> (r_pres >= r_thr))
        else $error("admitted entry below threshold");

    a_batch_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADMIT) |-> (r_cnt < r_limit))
        else $error("admit batch ran past its limit");

endmodule

FILE: hw/rtl/threshold_priority_batch_admitter.sv
// top level: sorted pending queue as a cell chain with batch admission
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_cmd, i_pressure, i_query_tag
//  output   | o_out_valid / i_out_ready  | o_status, o_admitted_tag,
//           |                            | o_admitted_pressure, o_last
//  config   | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// on an enqueue every cell compares against the new pressure and the chain shifts behind
// the insertion point at the edge that accepts the command
// an admit first latches the batch limit, then pops the head for each result while the
// output is not stalled, the chain shifting one slot toward the head on each pop
// a single output register holds each result; a stalled output stalls the sequencer
// reset clears all slot valid bits at once; no clearing pass is needed
module threshold_priority_batch_admitter #(
    parameter int QUEUE_DEPTH     = 64,
    parameter int MAX_BATCH_LIMIT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [tpba_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [tpba_pkg::PRES_W-1:0] i_pressure,
    input  logic [tpba_pkg::TAG_W-1:0]  i_query_tag,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [tpba_pkg::TAG_W-1:0]  o_admitted_tag,
    output logic [tpba_pkg::PRES_W-1:0] o_admitted_pressure,
    output logic                        o_last
);
    import tpba_pkg::*;

    t_chain_op              chain_op;
    t_entry                 entries [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] stay;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    t_entry                 empty_entry;

    assign empty_entry = '0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_entry left_entry;
            t_entry right_entry;
            logic   left_stay;

            if (g == 0) begin : g_first
                assign left_entry = empty_entry;
                assign left_stay  = 1'b1;
            end else begin : g_mid
                assign left_entry = entries[g-1];
                assign left_stay  = stay[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_end
                assign right_entry = empty_entry;
            end else begin : g_inner
                assign right_entry = entries[g+1];
            end

            tpba_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (chain_op),
                .i_left      (left_entry),
                .i_left_stay (left_stay),
                .i_right     (right_entry),
                .o_entry     (entries[g]),
                .o_stay      (stay[g])
            );

            assign valid_vec[g] = entries[g].valid;
        end
    endgenerate

    tpba_ctrl #(
        .MAX_BATCH_LIMIT (MAX_BATCH_LIMIT)
    ) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cmd               (i_cmd),
        .i_pressure          (i_pressure),
        .i_query_tag         (i_query_tag),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_admitted_tag      (o_admitted_tag),
        .o_admitted_pressure (o_admitted_pressure),
        .o_last              (o_last),
        .i_head              (entries[0]),
        .i_second            (entries[1]),
        .i_full              (entries[QUEUE_DEPTH-1].valid),
        .o_chain_op          (chain_op)
    );

    // occupied slots always form a run from the head
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (valid_vec & QUEUE_DEPTH'(valid_vec + 1'b1)) == '0)
        else $error("hole in the occupied slots");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        entries[1].valid |-> (entries[0].pressure >= entries[1].pressure))
        else $error("head ranks below its neighbor");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (valid_vec == '0))
        else $error("slots still valid after reset");

endmodule
